[hw/rtl/bf3_pkg.sv]
package bf3_pkg;

	localparam int PIX_W  = 8;
	localparam int CH_N   = 3;
	localparam int COL_W  = 11;
	localparam int ROW_W  = 16;
	localparam int WID_W  = 12;
	localparam int CSUM_W = 10;
	localparam int TSUM_W = 12;
	localparam int LINE_W = 2 * CH_N * PIX_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [WID_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [ROW_W-1:0] HEIGHT_RST = 16'd480;
	localparam logic [WID_W-1:0] WIDTH_MIN  = 12'd3;
	localparam logic [ROW_W-1:0] HEIGHT_MIN = 16'd3;

	// floor(x * 3641 / 2^15) equals floor(x / 9) for every x below 2^15.
	localparam logic [11:0] RECIP9   = 12'd3641;
	localparam int          RECIP_SH = 15;
	localparam logic [TSUM_W-1:0] ROUND9 = 12'd4;

	typedef logic [CH_N-1:0][PIX_W-1:0]  pix_t;
	typedef logic [CH_N-1:0][CSUM_W-1:0] csum_t;
	typedef logic [CH_N-1:0][TSUM_W-1:0] tsum_t;

	typedef struct packed {
		logic clear;
		logic load_s2;
		logic load_s3;
	} win_ctrl_t;

	function automatic logic [PIX_W-1:0] mean9(input logic [TSUM_W-1:0] sum);
		logic [TSUM_W-1:0] x;
		logic [23:0]       p;
		x = sum + ROUND9;
		p = 24'(x) * 24'(RECIP9);
		return p[RECIP_SH +: PIX_W];
	endfunction

endpackage

[hw/rtl/bf3_line_mem.sv]
module bf3_line_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [bf3_pkg::LINE_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [bf3_pkg::LINE_W-1:0] wr_data
);

	logic [bf3_pkg::LINE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/bf3_win.sv]
module bf3_win (
	input  logic               clk,
	input  logic               arst_n,
	input  bf3_pkg::win_ctrl_t ctrl,
	input  bf3_pkg::pix_t      top,
	input  bf3_pkg::pix_t      mid,
	input  bf3_pkg::pix_t      px,
	output bf3_pkg::tsum_t     total_s3
);

	bf3_pkg::csum_t colsum;
	bf3_pkg::csum_t csum_s2;
	bf3_pkg::csum_t csa_q;
	bf3_pkg::csum_t csb_q;
	bf3_pkg::tsum_t total;

	// Each window column is kept as its per-channel sum over three rows.
	always_comb begin
		for (int c = 0; c < bf3_pkg::CH_N; c++) begin
			colsum[c] = bf3_pkg::CSUM_W'(top[c]) + bf3_pkg::CSUM_W'(mid[c])
				+ bf3_pkg::CSUM_W'(px[c]);
			total[c] = bf3_pkg::TSUM_W'(csa_q[c]) + bf3_pkg::TSUM_W'(csb_q[c])
				+ bf3_pkg::TSUM_W'(csum_s2[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			csum_s2 <= colsum;
		end
		if (ctrl.load_s3) begin
			total_s3 <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csa_q <= '0;
			csb_q <= '0;
		end else if (ctrl.clear) begin
			csa_q <= '0;
			csb_q <= '0;
		end else if (ctrl.load_s3) begin
			csa_q <= csb_q;
			csb_q <= csum_s2;
		end
	end

endmodule

[hw/rtl/box_filter_3x3_rgb_top.sv]
// Streaming 3x3 box filter for RGB pixels in raster order. It takes one pixel
// per clock while pix_stall is low and, for every pixel at row and column two
// or more, delivers the rounded mean of the 3x3 neighbourhood of the pixel one
// row up and one column left; border pixels give no item. The rate is set by
// the line memory, which serves one read and one write of the two stored rows
// each cycle. The frame size registers must be written by the user only while
// the filter is idle (not enforced); each write restarts the frame at row 0, column 0.
module box_filter_3x3_rgb_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bf3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic [7:0]                        pix_red,
	input  logic [7:0]                        pix_green,
	input  logic [7:0]                        pix_blue,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [7:0]                        avg_red,
	output logic [7:0]                        avg_green,
	output logic [7:0]                        avg_blue,
	output logic [10:0]                       out_col,
	output logic [15:0]                       out_row,
	output logic                              frame_end
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [bf3_pkg::WID_W-1:0] WIDTH_MAX = bf3_pkg::WID_W'(MAX_WIDTH);

	logic [bf3_pkg::WID_W-1:0] eff_w_q;
	logic [bf3_pkg::ROW_W-1:0] eff_h_q;
	logic [bf3_pkg::COL_W-1:0] col_q;
	logic [bf3_pkg::ROW_W-1:0] row_q;
	logic                      cfg_fire;
	logic                      cfg_restart;
	logic                      accept;
	logic                      col_end;
	logic                      last;
	logic                      emit;

	logic                      v_s1, v_s2, v_s3;
	logic                      emit_s1, emit_s2, emit_s3;
	logic                      last_s1, last_s2, last_s3;
	logic [bf3_pkg::COL_W-1:0] ocol_s1, ocol_s2, ocol_s3;
	logic [bf3_pkg::ROW_W-1:0] orow_s1, orow_s2, orow_s3;
	logic [AW-1:0]             addr_s1;
	bf3_pkg::pix_t             px_s1;

	logic                      adv1, adv2, adv3;
	logic                      rdy_out;
	logic [bf3_pkg::LINE_W-1:0] rd_data;
	bf3_pkg::pix_t             top, mid;
	bf3_pkg::pix_t             px_in;
	bf3_pkg::win_ctrl_t        win_ctrl;
	bf3_pkg::tsum_t            total_s3;

	logic                      res_valid_q;
	bf3_pkg::pix_t             avg_q;
	logic [bf3_pkg::COL_W-1:0] col_out_q;
	logic [bf3_pkg::ROW_W-1:0] row_out_q;
	logic                      fend_q;

	assign cfg_ready   = 1'b1;
	assign cfg_fire    = cfg_valid && cfg_ready;
	assign cfg_restart = cfg_fire && ((cfg_index == bf3_pkg::REG_IMAGE_WIDTH) ||
		(cfg_index == bf3_pkg::REG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= bf3_pkg::WIDTH_RST;
			eff_h_q <= bf3_pkg::HEIGHT_RST;
		end else if (cfg_fire) begin
			case (cfg_index)
				bf3_pkg::REG_IMAGE_WIDTH: begin
					if (cfg_data[bf3_pkg::WID_W-1:0] < bf3_pkg::WIDTH_MIN) begin
						eff_w_q <= bf3_pkg::WIDTH_MIN;
					end else if (32'(cfg_data[bf3_pkg::WID_W-1:0]) > MAX_WIDTH) begin
						eff_w_q <= WIDTH_MAX;
					end else begin
						eff_w_q <= cfg_data[bf3_pkg::WID_W-1:0];
					end
				end
				bf3_pkg::REG_IMAGE_HEIGHT: begin
					if (cfg_data < bf3_pkg::HEIGHT_MIN) begin
						eff_h_q <= bf3_pkg::HEIGHT_MIN;
					end else begin
						eff_h_q <= cfg_data;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stage readiness ripples back from the output register.
	assign rdy_out   = !res_valid_q || !res_stall;
	assign adv3      = v_s3 && (rdy_out || !emit_s3);
	assign adv2      = v_s2 && (!v_s3 || adv3);
	assign adv1      = v_s1 && (!v_s2 || adv2);
	assign pix_stall = v_s1 && !adv1;
	assign accept    = pix_valid && !pix_stall;

	assign col_end = ({1'b0, col_q} + 12'd1) >= eff_w_q;
	assign last    = col_end && (({1'b0, row_q} + 17'd1) >= {1'b0, eff_h_q});
	assign emit    = (row_q >= 16'd2) && (col_q >= 11'd2);
	assign px_in   = {pix_blue, pix_green, pix_red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= last ? '0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			if (adv3 && emit_s3) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			last_s1 <= last;
			ocol_s1 <= col_q - 11'd1;
			orow_s1 <= row_q - 16'd1;
			addr_s1 <= AW'(col_q);
			px_s1   <= px_in;
		end
		if (adv1) begin
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			ocol_s2 <= ocol_s1;
			orow_s2 <= orow_s1;
		end
		if (adv2) begin
			emit_s3 <= emit_s2;
			last_s3 <= last_s2;
			ocol_s3 <= ocol_s2;
			orow_s3 <= orow_s2;
		end
		if (adv3 && emit_s3) begin
			for (int c = 0; c < bf3_pkg::CH_N; c++) begin
				avg_q[c] <= bf3_pkg::mean9(total_s3[c]);
			end
			col_out_q <= ocol_s3;
			row_out_q <= orow_s3;
			fend_q    <= last_s3;
		end
	end

	// The upper half of a line word is the row two above, the lower half the row above.
	assign top = rd_data[bf3_pkg::LINE_W-1 -: bf3_pkg::LINE_W/2];
	assign mid = rd_data[bf3_pkg::LINE_W/2-1:0];

	bf3_line_mem #(
		.DEPTH(MAX_WIDTH),
		.AW   (AW)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(AW'(col_q)),
		.rd_data(rd_data),
		.wr_en  (adv1),
		.wr_addr(addr_s1),
		.wr_data({mid, px_s1})
	);

	assign win_ctrl.clear   = cfg_restart;
	assign win_ctrl.load_s2 = adv1;
	assign win_ctrl.load_s3 = adv2;

	bf3_win u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.top     (top),
		.mid     (mid),
		.px      (px_s1),
		.total_s3(total_s3)
	);

	assign res_valid = res_valid_q;
	assign avg_red   = avg_q[0];
	assign avg_green = avg_q[1];
	assign avg_blue  = avg_q[2];
	assign out_col   = col_out_q;
	assign out_row   = row_out_q;
	assign frame_end = fend_q;

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < eff_w_q))
		else $error("column counter reached the frame width");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap after the last pixel of the frame");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (row_out_q != '0 && col_out_q != '0))
		else $error("result item issued for a border pixel");

endmodule

[test/box_filter_3x3_rgb_checker.sv]
module box_filter_3x3_rgb_checker
	import bf3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	input  logic                  pix_stall,
	input  logic [7:0]            pix_red,
	input  logic [7:0]            pix_green,
	input  logic [7:0]            pix_blue,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  logic [7:0]            avg_red,
	input  logic [7:0]            avg_green,
	input  logic [7:0]            avg_blue,
	input  logic [10:0]           out_col,
	input  logic [15:0]           out_row,
	input  logic                  frame_end,
	output int unsigned           mismatches,
	output int unsigned           waiting
);

	localparam int LINE_LEN = 2048;

	typedef struct packed {
		pix_t        avg;
		logic [10:0] col;
		logic [15:0] row;
		logic        last;
	} mean_t;

	logic [WID_W-1:0] width_reg;
	logic [ROW_W-1:0] height_reg;
	pix_t             row_above [LINE_LEN];
	pix_t             row_two_up [LINE_LEN];
	pix_t             win [6];
	int unsigned      col_pos;
	int unsigned      row_pos;
	mean_t            expected_means [$];

	task automatic restart_frame();
		for (int k = 0; k < 6; k++) begin
			win[k] = '0;
		end
		col_pos = 0;
		row_pos = 0;
	endtask

	// The incoming pixel is the bottom right corner of the neighbourhood whose
	// center sits one row up and one column left.
	task automatic filter_pixel(input pix_t px);
		int unsigned w;
		int unsigned h;
		int unsigned sum;
		logic        last;
		pix_t        cur [3];
		mean_t       m;
		w = (width_reg < 3) ? 3 : ((width_reg > LINE_LEN) ? LINE_LEN : width_reg);
		h = (height_reg < 3) ? 3 : height_reg;
		last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
		cur[0] = row_two_up[col_pos];
		cur[1] = row_above[col_pos];
		cur[2] = px;
		row_two_up[col_pos] = cur[1];
		row_above[col_pos] = px;
		if (row_pos >= 2 && col_pos >= 2) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum = 0;
				for (int k = 0; k < 6; k++) begin
					sum += win[k][ch];
				end
				for (int k = 0; k < 3; k++) begin
					sum += cur[k][ch];
				end
				m.avg[ch] = 8'((sum + 4) / 9);
			end
			m.col = 11'(col_pos - 1);
			m.row = 16'(row_pos - 1);
			m.last = last;
			expected_means.push_back(m);
		end
		for (int k = 0; k < 3; k++) begin
			win[k] = win[k + 3];
			win[k + 3] = cur[k];
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = last ? 0 : ((row_pos + 1) & 16'hFFFF);
		end else begin
			col_pos++;
		end
	endtask

	task automatic check_result();
		mean_t got;
		mean_t want;
		got = {avg_blue, avg_green, avg_red, out_col, out_row, frame_end};
		if (expected_means.size() == 0) begin
			$display("%0t: expected no item, got rgb %0d %0d %0d row %0d col %0d end %0b",
				$time, got.avg[0], got.avg[1], got.avg[2], got.row, got.col, got.last);
			mismatches++;
		end else begin
			want = expected_means.pop_front();
			if (got !== want) begin
				$display("%0t: expected rgb %0d %0d %0d row %0d col %0d end %0b,",
					$time, want.avg[0], want.avg[1], want.avg[2], want.row, want.col,
					want.last);
				$display("%0t: got rgb %0d %0d %0d row %0d col %0d end %0b",
					$time, got.avg[0], got.avg[1], got.avg[2], got.row, got.col,
					got.last);
				mismatches++;
			end
		end
	endtask

	// Sampling on the falling edge sees the values that the next rising edge
	// will act on.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			for (int k = 0; k < LINE_LEN; k++) begin
				row_above[k] = '0;
				row_two_up[k] = '0;
			end
			restart_frame();
			expected_means.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_reg = cfg_data[WID_W-1:0];
					restart_frame();
				end else if (cfg_index == REG_IMAGE_HEIGHT) begin
					height_reg = cfg_data;
					restart_frame();
				end
			end
			if (pix_valid && !pix_stall)
				filter_pixel({pix_blue, pix_green, pix_red});
			if (res_valid && !res_stall)
				check_result();
		end
		waiting = expected_means.size();
	end

endmodule

[test/tb_box_filter_3x3_rgb_top.sv]
module tb_box_filter_3x3_rgb_top;
	import bf3_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE = 8;
	localparam int RANDOM_ITEMS = 450;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pix_valid;
	logic                  pix_stall;
	logic [7:0]            pix_red;
	logic [7:0]            pix_green;
	logic [7:0]            pix_blue;
	logic                  res_valid;
	logic                  res_stall;
	logic [7:0]            avg_red;
	logic [7:0]            avg_green;
	logic [7:0]            avg_blue;
	logic [10:0]           out_col;
	logic [15:0]           out_row;
	logic                  frame_end;
	int unsigned           mismatches;
	int unsigned           waiting;

	logic                  calm;
	int unsigned           idle_cycles;
	int unsigned           sent;
	int unsigned           n;
	logic [15:0]           wreg;
	logic [15:0]           hreg;

	box_filter_3x3_rgb_top DUT (.*);

	box_filter_3x3_rgb_checker checker_i (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= !calm && ($urandom_range(99) < 8);
		end
	end

	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [7:0] channel_value();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while (!calm && $urandom_range(99) < 8) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_red <= r;
		pix_green <= g;
		pix_blue <= b;
		do @(negedge clk); while (pix_stall);
		@(posedge clk);
	endtask

	task automatic stream_pixels(input int unsigned count);
		repeat (count) send_pixel(channel_value(), channel_value(), channel_value());
	endtask

	// Registers change only once the filter has drained.
	task automatic set_frame_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		pix_valid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		pix_valid <= 1'b0;
		pix_red <= '0;
		pix_green <= '0;
		pix_blue <= '0;
		calm <= 1'b0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame, with the upper bits of the width ignored; two full
		// frames back to back at the channel extremes.
		set_frame_reg(REG_IMAGE_WIDTH, 16'hF003);
		set_frame_reg(REG_IMAGE_HEIGHT, 16'd3);
		repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
		repeat (9) send_pixel(8'h00, 8'h00, 8'h00);

		// Sizes below the minimum act as three; sums that sit at the rounding
		// point and near the top of the range.
		set_frame_reg(REG_IMAGE_WIDTH, 16'd0);
		set_frame_reg(REG_IMAGE_HEIGHT, 16'd1);
		for (int k = 0; k < 9; k++) begin
			send_pixel(8'(k < 5), 8'(k < 4), (k == 4) ? 8'hFE : 8'hFF);
		end

		// A full wide frame, sent without any idling.
		calm <= 1'b1;
		set_frame_reg(REG_IMAGE_WIDTH, 16'd200);
		set_frame_reg(REG_IMAGE_HEIGHT, 16'd4);
		stream_pixels(4 * 200);
		calm <= 1'b0;

		// An oversized width acts as the widest; the tallest frame is cut short
		// by the next register write.
		set_frame_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
		set_frame_reg(REG_IMAGE_WIDTH, 16'd4095);
		stream_pixels(24);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wreg = ($urandom_range(7) == 0) ? 16'($urandom_range(11, 64)) :
				16'($urandom_range(3, 10));
			if ($urandom_range(15) == 0)
				wreg = 16'($urandom_range(0, 2));
			hreg = ($urandom_range(15) == 0) ? 16'($urandom_range(0, 2)) :
				16'($urandom_range(3, 7));
			n = ((wreg < 3) ? 3 : wreg) * ((hreg < 3) ? 3 : hreg) * $urandom_range(1, 3);
			if ($urandom_range(3) == 0)
				n = $urandom_range(1, n);
			if (sent + n > RANDOM_ITEMS)
				n = RANDOM_ITEMS - sent;
			if ($urandom_range(7) == 0)
				wreg[15:12] = 4'($urandom_range(1, 15));
			if ($urandom_range(1)) begin
				set_frame_reg(REG_IMAGE_WIDTH, wreg);
				set_frame_reg(REG_IMAGE_HEIGHT, hreg);
			end else begin
				set_frame_reg(REG_IMAGE_HEIGHT, hreg);
				set_frame_reg(REG_IMAGE_WIDTH, wreg);
			end
			stream_pixels(n);
			sent += n;
		end

		pix_valid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && waiting == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/bf3_pkg.sv
hw/rtl/bf3_line_mem.sv
hw/rtl/bf3_win.sv
hw/rtl/box_filter_3x3_rgb_top.sv
test/box_filter_3x3_rgb_checker.sv
test/tb_box_filter_3x3_rgb_top.sv
